### rtl/tjd_pkg.sv
// shared types, constants and the step program for the trend jump detector
// no dependencies; imported by tjd_ctrl, tjd_dp and trend_jump_detector
package tjd_pkg;

    localparam int MAX_SAMPLES = 1024;
    localparam int MIN_TEST    = 2;

    localparam int CNT_W  = 11;
    localparam int X_W    = 16;
    localparam int Y_W    = 32;
    localparam int SX_W   = 26;
    localparam int SXX_W  = 42;
    localparam int SY_W   = 42;
    localparam int SXY_W  = 58;
    localparam int THR_W  = 16;
    localparam int XSQ_W  = 32;
    localparam int XY_W   = 48;

    localparam logic signed [THR_W-1:0] THR_RESET = 16'sd410;

    // every intermediate of the exact test fits in this many bits, signed
    localparam int ACC_W     = 104;
    localparam int CHUNK_W   = 32;
    localparam int N_CHUNKS  = 4;
    localparam int AFULL_W   = N_CHUNKS * CHUNK_W;
    localparam int OPB_W     = 33;
    localparam int PROD_W    = CHUNK_W + 1 + OPB_W;
    localparam int ERR_SHIFT = 12;

    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] LAST_STEP = 5'd25;

    // multiplier operand a, taken one 32-bit chunk at a time
    typedef enum logic [3:0] {
        A_X, A_Y, A_SX, A_SXX, A_SY, A_SXY, A_ACO, A_DET, A_NUM
    } t_asel;

    // multiplier operand b, 33-bit signed
    typedef enum logic [2:0] {
        B_X, B_Y, B_N, B_SX, B_SY_LO, B_SY_HI, B_THR
    } t_bsel;

    // register that takes the accumulator after a step
    typedef enum logic [2:0] {
        D_NONE, D_XSQ, D_XY, D_DET, D_ACO, D_NUM, D_ERR
    } t_dst;

    typedef struct packed {
        logic        valid;
        logic        clr;
        logic        neg;
        logic        sub_num;
        t_asel       a_sel;
        logic [1:0]  a_chunk;
        t_bsel       b_sel;
        logic [1:0]  shift;
        t_dst        dst;
    } t_cmd;

    typedef struct packed {
        logic load;
        logic commit;
        t_cmd cmd;
    } t_ctrl;

    function automatic t_cmd mk(input logic clr, input logic neg, input t_asel a_sel,
                                input logic [1:0] a_chunk, input t_bsel b_sel,
                                input logic [1:0] shift, input t_dst dst);
        t_cmd c;
        c.valid   = 1'b1;
        c.clr     = clr;
        c.neg     = neg;
        c.sub_num = 1'b0;
        c.a_sel   = a_sel;
        c.a_chunk = a_chunk;
        c.b_sel   = b_sel;
        c.shift   = shift;
        c.dst     = dst;
        return c;
    endfunction

    // det = N*Sxx - Sx*Sx, aco = N*Sxy - Sx*Sy,
    // num = Sy*Sxx - Sx*Sxy + aco*x, err = y*det - num, tp = num*thr
    function automatic t_cmd step_cmd(input logic [STEP_W-1:0] step);
        t_cmd c;
        c = '0;
        case (step)
            5'd0:  c = mk(1'b1, 1'b0, A_X,   2'd0, B_X,     2'd0, D_XSQ);
            5'd1:  c = mk(1'b1, 1'b0, A_Y,   2'd0, B_X,     2'd0, D_XY);
            5'd2:  c = mk(1'b1, 1'b0, A_SXX, 2'd0, B_N,     2'd0, D_NONE);
            5'd3:  c = mk(1'b0, 1'b0, A_SXX, 2'd1, B_N,     2'd1, D_NONE);
            5'd4:  c = mk(1'b0, 1'b1, A_SX,  2'd0, B_SX,    2'd0, D_DET);
            5'd5:  c = mk(1'b1, 1'b0, A_SXY, 2'd0, B_N,     2'd0, D_NONE);
            5'd6:  c = mk(1'b0, 1'b0, A_SXY, 2'd1, B_N,     2'd1, D_NONE);
            5'd7:  c = mk(1'b0, 1'b1, A_SY,  2'd0, B_SX,    2'd0, D_NONE);
            5'd8:  c = mk(1'b0, 1'b1, A_SY,  2'd1, B_SX,    2'd1, D_ACO);
            5'd9:  c = mk(1'b1, 1'b0, A_SXX, 2'd0, B_SY_LO, 2'd0, D_NONE);
            5'd10: c = mk(1'b0, 1'b0, A_SXX, 2'd0, B_SY_HI, 2'd1, D_NONE);
            5'd11: c = mk(1'b0, 1'b0, A_SXX, 2'd1, B_SY_LO, 2'd1, D_NONE);
            5'd12: c = mk(1'b0, 1'b0, A_SXX, 2'd1, B_SY_HI, 2'd2, D_NONE);
            5'd13: c = mk(1'b0, 1'b1, A_SXY, 2'd0, B_SX,    2'd0, D_NONE);
            5'd14: c = mk(1'b0, 1'b1, A_SXY, 2'd1, B_SX,    2'd1, D_NONE);
            5'd15: c = mk(1'b0, 1'b0, A_ACO, 2'd0, B_X,     2'd0, D_NONE);
            5'd16: c = mk(1'b0, 1'b0, A_ACO, 2'd1, B_X,     2'd1, D_NONE);
            5'd17: c = mk(1'b0, 1'b0, A_ACO, 2'd2, B_X,     2'd2, D_NONE);
            5'd18: c = mk(1'b0, 1'b0, A_ACO, 2'd3, B_X,     2'd3, D_NUM);
            5'd19: c = mk(1'b1, 1'b0, A_DET, 2'd0, B_Y,     2'd0, D_NONE);
            5'd20: c = mk(1'b0, 1'b0, A_DET, 2'd1, B_Y,     2'd1, D_NONE);
            5'd21: begin
                c = mk(1'b0, 1'b0, A_NUM, 2'd0, B_Y, 2'd0, D_ERR);
                c.sub_num = 1'b1;
            end
            5'd22: c = mk(1'b1, 1'b0, A_NUM, 2'd0, B_THR,   2'd0, D_NONE);
            5'd23: c = mk(1'b0, 1'b0, A_NUM, 2'd1, B_THR,   2'd1, D_NONE);
            5'd24: c = mk(1'b0, 1'b0, A_NUM, 2'd2, B_THR,   2'd2, D_NONE);
            5'd25: c = mk(1'b0, 1'b0, A_NUM, 2'd3, B_THR,   2'd3, D_NONE);
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

### rtl/tjd_ctrl.sv
// sequencer for the trend jump detector: input/output handshake and step program
// depends on tjd_pkg
module tjd_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output tjd_pkg::t_ctrl o_ctrl
);
    import tjd_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_RUN    = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_DECIDE = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_out_valid, n_out_valid;
    logic              load, commit, out_free;

    // no beat is taken while reset is held
    assign o_in_ready  = (r_state == ST_IDLE) && i_rst_n;
    assign o_out_valid = r_out_valid;
    assign load        = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign commit      = (r_state == ST_DECIDE) && out_free;

    always_comb begin
        o_ctrl.load   = load;
        o_ctrl.commit = commit;
        o_ctrl.cmd    = (r_state == ST_RUN) ? step_cmd(r_step) : '0;
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            ST_IDLE: begin
                if (load) begin
                    n_state = ST_RUN;
                    n_step  = '0;
                end
            end
            ST_RUN: begin
                if (r_step == LAST_STEP) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            // last product still in the accumulate stage
            ST_DRAIN: n_state = ST_DECIDE;
            ST_DECIDE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        if (commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= LAST_STEP)
        else $error("step counter past end of program");

    a_load_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> (r_state == ST_RUN) && (r_step == '0))
        else $error("accepted beat did not start the program");

    a_drain_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN) |-> ($past(r_state) == ST_RUN) && ($past(r_step) == LAST_STEP))
        else $error("drain entered before the last step");

    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> r_out_valid)
        else $error("result committed but not presented");

endmodule

### rtl/tjd_dp.sv
// datapath: running sums, shared 33x33 multiplier with accumulator, jump test
// depends on tjd_pkg; driven by tjd_ctrl
module tjd_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tjd_pkg::t_ctrl                i_ctrl,
    input  logic                          i_cfg_we,
    input  logic [tjd_pkg::THR_W-1:0]     i_cfg_wdata,
    input  logic                          i_start_new,
    input  logic [tjd_pkg::X_W-1:0]       i_position,
    input  logic [tjd_pkg::Y_W-1:0]       i_measured,
    output logic                          o_jump_seen,
    output logic [tjd_pkg::CNT_W-1:0]     o_sample_count,
    output logic                          o_overflow
);
    import tjd_pkg::*;

    // configuration and accumulated state
    logic signed [THR_W-1:0] r_thr;
    logic [CNT_W-1:0]        r_count;
    logic [SX_W-1:0]         r_sx;
    logic [SXX_W-1:0]        r_sxx;
    logic [SY_W-1:0]         r_sy;
    logic [SXY_W-1:0]        r_sxy;
    logic                    r_flag;

    // per-sample working registers
    logic [X_W-1:0]          r_x;
    logic [Y_W-1:0]          r_y;
    logic [XSQ_W-1:0]        r_xsq;
    logic [XY_W-1:0]         r_xy;
    logic signed [ACC_W-1:0] r_acc, r_det, r_aco, r_num, r_err;
    logic signed [PROD_W-1:0] r_prod;
    t_cmd                    r_cmd2;

    logic                    r_out_jump, r_out_ovf;
    logic [CNT_W-1:0]        r_out_cnt;

    logic [AFULL_W-1:0]       a_full;
    logic [CHUNK_W-1:0]       a_chunk;
    logic [OPB_W-1:0]         b_op;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  term, term_sh, acc_base, acc_next, err_s;
    logic                     thr_nz, thr_pos, want_gt, cmp, hit, full, flag_next;
    logic [CNT_W-1:0]         count_next;

    // stage 1: operand select and multiply
    always_comb begin
        unique case (i_ctrl.cmd.a_sel)
            A_X:     a_full = AFULL_W'(r_x);
            A_Y:     a_full = AFULL_W'(r_y);
            A_SX:    a_full = AFULL_W'(r_sx);
            A_SXX:   a_full = AFULL_W'(r_sxx);
            A_SY:    a_full = AFULL_W'(r_sy);
            A_SXY:   a_full = AFULL_W'(r_sxy);
            A_ACO:   a_full = AFULL_W'(unsigned'(r_aco));
            A_DET:   a_full = AFULL_W'(unsigned'(r_det));
            A_NUM:   a_full = AFULL_W'(unsigned'(r_num));
            default: a_full = '0;
        endcase
        a_chunk = a_full[i_ctrl.cmd.a_chunk * CHUNK_W +: CHUNK_W];

        unique case (i_ctrl.cmd.b_sel)
            B_X:     b_op = OPB_W'(r_x);
            B_Y:     b_op = OPB_W'(r_y);
            B_N:     b_op = OPB_W'(r_count);
            B_SX:    b_op = OPB_W'(r_sx);
            B_SY_LO: b_op = OPB_W'(r_sy[CHUNK_W-1:0]);
            B_SY_HI: b_op = OPB_W'(r_sy[SY_W-1:CHUNK_W]);
            B_THR:   b_op = unsigned'(OPB_W'(r_thr));
            default: b_op = '0;
        endcase
        prod = $signed({1'b0, a_chunk}) * $signed(b_op);
    end

    // stage 2: shift into place and accumulate modulo 2^ACC_W
    always_comb begin
        term     = ACC_W'(r_prod);
        term_sh  = term << (r_cmd2.shift * CHUNK_W);
        acc_base = r_cmd2.clr ? '0 : r_acc;
        if (r_cmd2.sub_num) begin
            acc_next = acc_base - r_num;
        end else if (r_cmd2.neg) begin
            acc_next = acc_base - term_sh;
        end else begin
            acc_next = acc_base + term_sh;
        end
    end

    // the test: err/num against thr, with the sign of num folded into the compare
    always_comb begin
        err_s      = r_err <<< ERR_SHIFT;
        thr_nz     = (r_thr != '0);
        thr_pos    = !r_thr[THR_W-1] && thr_nz;
        want_gt    = thr_pos != r_num[ACC_W-1];
        cmp        = want_gt ? (r_acc < err_s) : (err_s < r_acc);
        hit        = (r_count >= CNT_W'(MIN_TEST)) && thr_nz && (r_det != '0)
                     && (r_num != '0) && cmp;
        full       = (r_count >= CNT_W'(MAX_SAMPLES));
        count_next = full ? r_count : r_count + CNT_W'(1);
        flag_next  = r_flag || hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr   <= THR_RESET;
            r_count <= '0;
            r_sx    <= '0;
            r_sxx   <= '0;
            r_sy    <= '0;
            r_sxy   <= '0;
            r_flag  <= 1'b0;
            r_cmd2  <= '0;
        end else begin
            r_cmd2 <= i_ctrl.cmd;
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            if (i_ctrl.load && i_start_new) begin
                r_count <= '0;
                r_sx    <= '0;
                r_sxx   <= '0;
                r_sy    <= '0;
                r_sxy   <= '0;
                r_flag  <= 1'b0;
            end
            if (i_ctrl.commit) begin
                r_flag  <= flag_next;
                r_count <= count_next;
                if (!full) begin
                    r_sx  <= r_sx + SX_W'(r_x);
                    r_sxx <= r_sxx + SXX_W'(r_xsq);
                    r_sy  <= r_sy + SY_W'(r_y);
                    r_sxy <= r_sxy + SXY_W'(r_xy);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_x <= i_position;
            r_y <= i_measured;
        end
        r_prod <= prod;
        if (r_cmd2.valid) begin
            r_acc <= acc_next;
            unique case (r_cmd2.dst)
                D_NONE: ;
                D_XSQ:  r_xsq <= unsigned'(acc_next[XSQ_W-1:0]);
                D_XY:   r_xy  <= unsigned'(acc_next[XY_W-1:0]);
                D_DET:  r_det <= acc_next;
                D_ACO:  r_aco <= acc_next;
                D_NUM:  r_num <= acc_next;
                D_ERR:  r_err <= acc_next;
                default: ;
            endcase
        end
        if (i_ctrl.commit) begin
            r_out_jump <= flag_next;
            r_out_cnt  <= count_next;
            r_out_ovf  <= full;
        end
    end

    assign o_jump_seen    = r_out_jump;
    assign o_sample_count = r_out_cnt;
    assign o_overflow     = r_out_ovf;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_SAMPLES))
        else $error("sample count beyond store size");

    a_det_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cmd2.valid && (r_cmd2.dst == D_DET)) |=> !r_det[ACC_W-1])
        else $error("determinant came out negative");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.commit && (r_count < CNT_W'(MAX_SAMPLES)))
        |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("sample count did not advance on commit");

endmodule

### rtl/trend_jump_detector.sv
// top level of the least-squares trend jump detector
// depends on tjd_pkg, tjd_ctrl, tjd_dp
//
//  channel  | dir | handshake                    | payload
//  ---------+-----+------------------------------+-----------------------------------------
//  s_axis   | in  | s_axis_tvalid/s_axis_tready  | tdata: position, measured; tuser: start_new
//  m_axis   | out | m_axis_tvalid/m_axis_tready  | tdata: jump_seen, sample_count, overflow
//  cfg      | in  | i_cfg_we                     | i_cfg_wdata: jump_threshold
//
// a sample runs from accept to commit through 26 steps on the single
// 33x33 multiplier, one accumulate drain, one decide; the result is presented right
// after the commit edge, and the next beat is taken only once the sample is committed
// a waiting result holds the decide step, and no new sample is taken meanwhile
// reset (synchronous, active low) clears the sums, count and flag, threshold to 410
module trend_jump_detector (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // position [15:0], measured [47:16]
    input  logic [0:0]  s_axis_tuser,   // start_new [0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // jump_seen [0], sample_count [11:1], overflow [12]
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);
    import tjd_pkg::*;

    t_ctrl            ctrl;
    logic             jump_seen, overflow;
    logic [CNT_W-1:0] sample_count;

    tjd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_ctrl      (ctrl)
    );

    tjd_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (ctrl),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_start_new    (s_axis_tuser[0]),
        .i_position     (s_axis_tdata[15:0]),
        .i_measured     (s_axis_tdata[47:16]),
        .o_jump_seen    (jump_seen),
        .o_sample_count (sample_count),
        .o_overflow     (overflow)
    );

    assign m_axis_tdata = {3'b000, overflow, sample_count, jump_seen};

endmodule
